// File: design/bfca_pkg.sv
`timescale 1ns / 1ps

package bfca_pkg;

    localparam int CAP_W   = 32;
    localparam int VAL_W   = 24;
    localparam int TOTAL_W = 48;

    // request types
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_PLACE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PLACED   = 2'd2;
    localparam logic [1:0] ST_NOFIT    = 2'd3;

    // operation broadcast to every cell in the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [CAP_W-1:0] key;
    } t_cell_op;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic             valid;
        logic [CAP_W-1:0] val;
    } t_link;

endpackage

// File: design/bfca_cell.sv
`timescale 1ns / 1ps

module bfca_cell import bfca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_op         i_op,
    input  t_link            i_left,
    input  logic             i_left_stay,
    input  logic             i_left_ge,
    input  t_link            i_right,
    output t_link            o_self,
    output logic             o_stay,
    output logic             o_ge,
    output logic [CAP_W:0]   o_leaf
);

    logic             r_valid;
    logic [CAP_W-1:0] r_val;
    logic             n_valid;
    logic [CAP_W-1:0] n_val;
    logic [CAP_W:0]   r_leaf;
    logic             w_stay;
    logic             w_ge;
    logic             w_hit;

    // empty cells sort as larger than any key
    assign w_stay = r_valid && (r_val <= i_op.key);
    assign w_ge   = !r_valid || (r_val >= i_op.key);
    // first stored entry at or above the key
    assign w_hit  = r_valid && w_ge && !i_left_ge;

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        if (i_op.ins && !w_stay) begin
            if (i_left_stay) begin
                n_valid = 1'b1;
                n_val   = i_op.key;
            end else begin
                n_valid = i_left.valid;
                n_val   = i_left.val;
            end
        end else if (i_op.rem && w_ge) begin
            // close the gap: pull from the right neighbor
            n_valid = i_right.valid;
            n_val   = i_right.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_op.rem) begin
            r_leaf <= w_hit ? {1'b1, r_val} : '0;
        end
    end

    assign o_self.valid = r_valid;
    assign o_self.val   = r_val;
    assign o_stay       = w_stay;
    assign o_ge         = w_ge;
    assign o_leaf       = r_leaf;

endmodule

// File: design/bfca_or_tree.sv
`timescale 1ns / 1ps

module bfca_or_tree #(
    parameter int N = 1024,
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);

    localparam int NL = $clog2(N);
    localparam int NP = 1 << NL;

    // heap layout: node k combines nodes 2k and 2k+1, leaves start at NP
    logic [W-1:0] node [1:2*NP-1];

    genvar k;
    generate
        for (k = NP; k < 2 * NP; k++) begin : g_leaf
            if (k - NP < N) begin : g_used
                assign node[k] = i_leaf[k-NP];
            end else begin : g_pad
                assign node[k] = '0;
            end
        end
        for (k = 1; k < NP; k++) begin : g_node
            localparam int LV = $clog2(k + 1) - 1;
            if (((NL - LV) % 5) == 0) begin : g_reg
                // pipeline break every fifth level
                always_ff @(posedge i_clk) begin
                    node[k] <= node[2*k] | node[2*k+1];
                end
            end else begin : g_comb
                assign node[k] = node[2*k] | node[2*k+1];
            end
        end
    endgenerate

    assign o_root = node[1];

endmodule

// File: design/best_fit_capacity_assigner_top.sv
`timescale 1ns / 1ps

// Best-fit bin store: a sorted chain of MAX_BINS cells holding bin capacities
// in ascending order. An insert runs through EXEC, in which the chain shifts
// the new capacity into place, then registers its result. A place runs through
// EXEC, in which the chain finds the smallest fitting capacity and closes the
// gap behind it, then the OR tree that brings that capacity out of the chain,
// registered every fifth level, while WAIT waits out the tree's registers.
// busy is high from the cycle after start until the result strobe; a new
// start is taken in the strobe cycle. Each result is on the ports for one
// cycle with o_valid high and cannot be held off, so the receiver must take
// it then. The store is empty after reset with no extra clearing time. Place
// items are expected in non-increasing value order.
module best_fit_capacity_assigner_top import bfca_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [CAP_W-1:0]   i_weight_or_capacity,
    input  logic [VAL_W-1:0]   i_item_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [CAP_W-1:0]   o_capacity_used,
    output logic [TOTAL_W-1:0] o_running_total
);

    localparam int TREE_LAT = $clog2(MAX_BINS) / 5;
    localparam int CW       = $clog2(TREE_LAT + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic               r_req;
    logic [CAP_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [1:0]         r_out_status;
    logic [1:0]         n_out_status;
    logic [CAP_W-1:0]   r_out_cap;
    logic [CAP_W-1:0]   n_out_cap;
    logic [TOTAL_W:0]   w_sum;
    logic               w_full;
    logic               w_accept;
    t_cell_op           w_op;

    t_link              w_link [MAX_BINS];
    logic               w_stay [MAX_BINS];
    logic               w_ge   [MAX_BINS];
    logic [CAP_W:0]     w_leaf [MAX_BINS];
    logic [CAP_W:0]     w_root;

    assign w_accept = start && !busy;
    assign w_full   = w_link[MAX_BINS-1].valid;

    assign w_op.ins = (r_state == S_EXEC) && (r_req == REQ_INSERT) && !w_full;
    assign w_op.rem = (r_state == S_EXEC) && (r_req == REQ_PLACE);
    assign w_op.key = r_key;

    genvar i;
    generate
        for (i = 0; i < MAX_BINS; i++) begin : g_cell
            t_link w_left;
            t_link w_right;
            logic  w_left_stay;
            logic  w_left_ge;
            if (i == 0) begin : g_head
                // a new capacity enters at the head when it is the smallest
                assign w_left      = '0;
                assign w_left_stay = 1'b1;
                assign w_left_ge   = 1'b0;
            end else begin : g_body
                assign w_left      = w_link[i-1];
                assign w_left_stay = w_stay[i-1];
                assign w_left_ge   = w_ge[i-1];
            end
            if (i == MAX_BINS - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_mid
                assign w_right = w_link[i+1];
            end
            bfca_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (w_op),
                .i_left      (w_left),
                .i_left_stay (w_left_stay),
                .i_left_ge   (w_left_ge),
                .i_right     (w_right),
                .o_self      (w_link[i]),
                .o_stay      (w_stay[i]),
                .o_ge        (w_ge[i]),
                .o_leaf      (w_leaf[i])
            );
        end
    endgenerate

    bfca_or_tree #(
        .N (MAX_BINS),
        .W (CAP_W + 1)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    assign w_sum = {1'b0, r_total} + {{(TOTAL_W + 1 - VAL_W){1'b0}}, r_val};

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_total      = r_total;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_cap    = r_out_cap;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_req == REQ_INSERT) begin
                    n_out_valid  = 1'b1;
                    n_out_status = w_full ? ST_FULL : ST_INSERTED;
                    n_out_cap    = '0;
                    n_state      = S_IDLE;
                end else begin
                    n_cnt   = CW'(TREE_LAT);
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (r_cnt == '0) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (w_root[CAP_W]) begin
                        n_out_status = ST_PLACED;
                        n_out_cap    = w_root[CAP_W-1:0];
                        // saturate the total
                        n_total      = w_sum[TOTAL_W] ? {TOTAL_W{1'b1}}
                                                      : w_sum[TOTAL_W-1:0];
                    end else begin
                        n_out_status = ST_NOFIT;
                        n_out_cap    = '0;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_cap    <= n_out_cap;
        if (w_accept) begin
            r_req <= i_req_type;
            r_key <= i_weight_or_capacity;
            r_val <= i_item_value;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_capacity_used = r_out_cap;
    assign o_running_total = r_total;

endmodule
